// File: src/swor_pkg.sv
// Shared types and constants for the sliding-window outlier filter.
`default_nettype none

package swor_pkg;

    // Field widths of the sample and result transactions.
    localparam int STAMP_BITS = 31;
    localparam int VALUE_BITS = 24;
    localparam int KEPT_BITS  = 32;

    // Default window length.
    localparam int WINDOW_DEF = 5;

    // Difference of two samples needs one extra bit; its square fits twice the value width.
    localparam int DIFF_BITS = VALUE_BITS + 1;
    localparam int SQ_BITS   = 2 * VALUE_BITS;

    // One incoming sample.
    typedef struct packed {
        logic [STAMP_BITS-1:0]        stamp;
        logic signed [VALUE_BITS-1:0] sample;
        logic                         end_of_stream;
    } sample_t;

    // One kept sample.
    typedef struct packed {
        logic [STAMP_BITS-1:0]        out_stamp;
        logic signed [VALUE_BITS-1:0] out_sample;
        logic                         final_res;
        logic [KEPT_BITS-1:0]         kept_total;
    } result_t;

endpackage

`default_nettype wire

// File: src/swor_cell.sv
// One window slot: holds a sample, shifts it on, and squares its distance to the centre.
`default_nettype none

module swor_cell (
    input  wire logic                                   clk,
    input  wire logic                                   shift,
    input  wire logic                                   en,
    input  wire logic [swor_pkg::STAMP_BITS-1:0]        load_stamp,
    input  wire logic signed [swor_pkg::VALUE_BITS-1:0] load_value,
    input  wire logic signed [swor_pkg::VALUE_BITS-1:0] centre,
    output logic [swor_pkg::STAMP_BITS-1:0]             stamp,
    output logic signed [swor_pkg::VALUE_BITS-1:0]      value,
    output logic signed [swor_pkg::DIFF_BITS-1:0]       diff,
    output logic [swor_pkg::SQ_BITS-1:0]                sq
);

    logic [swor_pkg::STAMP_BITS-1:0]        stamp_reg;
    logic signed [swor_pkg::VALUE_BITS-1:0] value_reg;
    logic signed [swor_pkg::DIFF_BITS-1:0]  diff_reg;
    logic signed [swor_pkg::DIFF_BITS-1:0]  diff_next;
    logic [swor_pkg::SQ_BITS-1:0]           sq_reg;
    logic [swor_pkg::SQ_BITS-1:0]           sq_next;
    logic [swor_pkg::DIFF_BITS-1:0]         diff_neg;
    logic [swor_pkg::VALUE_BITS-1:0]        mag;

    // Distance to the centre sample and its square; the magnitude always fits the value width.
    always_comb
    begin
        diff_next = $signed({value_reg[swor_pkg::VALUE_BITS-1], value_reg})
                  - $signed({centre[swor_pkg::VALUE_BITS-1], centre});
        diff_neg  = ~diff_next + 1'b1;
        mag       = diff_next[swor_pkg::DIFF_BITS-1] ? diff_neg[swor_pkg::VALUE_BITS-1:0]
                                                     : diff_next[swor_pkg::VALUE_BITS-1:0];
        sq_next   = {{swor_pkg::VALUE_BITS{1'b0}}, mag} * {{swor_pkg::VALUE_BITS{1'b0}}, mag};
    end

    // Sample storage moves one slot along the chain per accepted transaction.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            stamp_reg <= load_stamp;
            value_reg <= load_value;
        end
        if (en)
        begin
            diff_reg <= diff_next;
            sq_reg   <= sq_next;
        end
    end

    assign stamp = stamp_reg;
    assign value = value_reg;
    assign diff  = diff_reg;
    assign sq    = sq_reg;

endmodule

`default_nettype wire

// File: src/swor_judge.sv
// Window statistics: sums the distances and squares, then compares 2*D^2 against WINDOW*A.
`default_nettype none

module swor_judge #(
    parameter int WINDOW = swor_pkg::WINDOW_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [swor_pkg::DIFF_BITS-1:0] diff [WINDOW],
    input  wire logic [swor_pkg::SQ_BITS-1:0]          sq [WINDOW],
    output logic                                       keep
);

    localparam int SUM_GROW  = $clog2(WINDOW);
    localparam int D_BITS    = swor_pkg::DIFF_BITS + SUM_GROW;
    localparam int DMAG_BITS = swor_pkg::VALUE_BITS + SUM_GROW;
    localparam int A_BITS    = swor_pkg::SQ_BITS + SUM_GROW;
    localparam int L_BITS    = 2 * DMAG_BITS;
    localparam int R_BITS    = A_BITS + $clog2(WINDOW + 1);
    localparam int CMP_BITS  = (L_BITS + 1 > R_BITS) ? L_BITS + 1 : R_BITS;

    logic signed [D_BITS-1:0] d_reg;
    logic signed [D_BITS-1:0] d_next;
    logic [A_BITS-1:0]        a_reg;
    logic [A_BITS-1:0]        a_next;
    logic [D_BITS-1:0]        d_neg;
    logic [DMAG_BITS-1:0]     d_mag;
    logic [L_BITS-1:0]        l_reg;
    logic [L_BITS-1:0]        l_next;
    logic [R_BITS-1:0]        r_reg;
    logic [R_BITS-1:0]        r_next;

    // Sum of distances and sum of squared distances over the window.
    always_comb
    begin
        d_next = '0;
        a_next = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            d_next = d_next
                   + $signed({{SUM_GROW{diff[i][swor_pkg::DIFF_BITS-1]}}, diff[i]});
            a_next = a_next + {{SUM_GROW{1'b0}}, sq[i]};
        end
    end

    // Square of the distance sum and the scaled sum of squares.
    always_comb
    begin
        d_neg  = ~d_reg + 1'b1;
        d_mag  = d_reg[D_BITS-1] ? d_neg[DMAG_BITS-1:0] : d_reg[DMAG_BITS-1:0];
        l_next = {{DMAG_BITS{1'b0}}, d_mag} * {{DMAG_BITS{1'b0}}, d_mag};
        r_next = R_BITS'(a_reg) * R_BITS'(WINDOW);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            a_reg <= a_next;
            l_reg <= l_next;
            r_reg <= r_next;
        end
    end

    // The centre sample lies strictly inside one standard deviation.
    assign keep = CMP_BITS'({l_reg, 1'b0}) < CMP_BITS'(r_reg);

endmodule

`default_nettype wire

// File: src/swor_emit.sv
// Result sequencer: sends a job's kept samples, one per cycle unless stalled, with the kept count.
`default_nettype none

module swor_emit #(
    parameter  int WINDOW   = swor_pkg::WINDOW_DEF,
    localparam int LEAD     = (WINDOW - 1) / 2,
    localparam int SEL_BITS = $clog2(LEAD + 1)
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   job_valid,
    output logic                                        job_ready,
    input  wire logic [LEAD:0]                          job_mask,
    input  wire logic                                   job_eos,
    input  wire logic [swor_pkg::STAMP_BITS-1:0]        job_stamp [LEAD+1],
    input  wire logic signed [swor_pkg::VALUE_BITS-1:0] job_value [LEAD+1],
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output swor_pkg::result_t                           result_item
);

    logic [LEAD:0]                          mask_reg;
    logic [LEAD:0]                          mask_next;
    logic [LEAD:0]                          mask_after;
    logic [LEAD:0]                          low_bit;
    logic                                   eos_reg;
    logic [swor_pkg::STAMP_BITS-1:0]        stamp_reg [LEAD+1];
    logic signed [swor_pkg::VALUE_BITS-1:0] value_reg [LEAD+1];
    logic                                   result_valid_reg;
    logic                                   result_valid_next;
    swor_pkg::result_t                      item_reg;
    swor_pkg::result_t                      item_next;
    logic [swor_pkg::KEPT_BITS-1:0]         kept_reg;
    logic [swor_pkg::KEPT_BITS-1:0]         kept_next;
    logic [swor_pkg::KEPT_BITS-1:0]         kept_inc;
    logic [SEL_BITS-1:0]                    sel;
    logic                                   out_free;
    logic                                   emit;
    logic                                   is_final;
    logic                                   load;

    // Oldest pending sample goes first.
    always_comb
    begin
        sel = '0;
        for (int j = LEAD; j >= 0; j--)
        begin
            if (mask_reg[j])
            begin
                sel = SEL_BITS'(j);
            end
        end
        low_bit = (LEAD + 1)'(1) << sel;
    end

    // Handshake between the pending job and the output register.
    always_comb
    begin
        out_free   = !result_valid_reg || result_ready;
        emit       = (|mask_reg) && out_free;
        mask_after = emit ? (mask_reg & ~low_bit) : mask_reg;
        job_ready  = (mask_after == '0);
        load       = job_ready && job_valid;
        mask_next  = job_ready ? (job_valid ? job_mask : '0) : mask_after;
    end

    // Output transaction and the saturating kept count, which restarts after the final one.
    always_comb
    begin
        kept_inc          = (kept_reg == '1) ? kept_reg : kept_reg + 1'b1;
        is_final          = eos_reg && (sel == SEL_BITS'(LEAD));
        result_valid_next = emit ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
        kept_next         = emit ? (is_final ? '0 : kept_inc) : kept_reg;
        item_next         = item_reg;
        if (emit)
        begin
            item_next.out_stamp  = stamp_reg[sel];
            item_next.out_sample = value_reg[sel];
            item_next.final_res  = is_final;
            item_next.kept_total = kept_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg         <= '0;
            result_valid_reg <= 1'b0;
            kept_reg         <= '0;
        end
        else
        begin
            mask_reg         <= mask_next;
            result_valid_reg <= result_valid_next;
            kept_reg         <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (load)
        begin
            eos_reg <= job_eos;
            for (int j = 0; j <= LEAD; j++)
            begin
                stamp_reg[j] <= job_stamp[j];
                value_reg[j] <= job_value[j];
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = item_reg;

endmodule

`default_nettype wire

// File: src/sliding_window_outlier_removal_core.sv
// Top level of the sliding-window outlier filter: cell chain, statistics pipeline and sequencer.
//
// Each sample is judged by the WINDOW samples around it and is kept when it lies strictly within
// one population standard deviation of the window mean, tested exactly as 2*D^2 < WINDOW*A on the
// distances to the centre sample. The first PRE and the last LEAD samples of a stream always pass.
// The block takes one sample per cycle while the output is not stalled; a sample's verdict
// passes through the distance stage, sum stage, product stage, sequencer and output register,
// and results lag the input by LEAD samples. Results leave through a single output register, one
// per cycle when not stalled, so an end-of-stream sample, which flushes up to LEAD+1 results,
// holds the input while they are sent. A stalled output stalls the whole pipeline.
`default_nettype none

module sliding_window_outlier_removal_core #(
    parameter int WINDOW = swor_pkg::WINDOW_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_ready,
    input  wire swor_pkg::sample_t sample_item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output swor_pkg::result_t      result_item
);

    localparam int HIST     = WINDOW - 1;
    localparam int LEAD     = (WINDOW - 1) / 2;
    localparam int PRE      = HIST - LEAD;
    localparam int CNT_BITS = $clog2(WINDOW);

    logic adv;
    logic accept;
    logic keep;

    // Cell chain: slot HIST is the newest sample, slot PRE the one under test.
    logic [swor_pkg::STAMP_BITS-1:0]        cell_stamp [WINDOW];
    logic signed [swor_pkg::VALUE_BITS-1:0] cell_value [WINDOW];
    logic signed [swor_pkg::DIFF_BITS-1:0]  cell_diff [WINDOW];
    logic [swor_pkg::SQ_BITS-1:0]           cell_sq [WINDOW];

    // Stream position and the job held in the cell chain.
    logic [CNT_BITS-1:0] seen_reg;
    logic [CNT_BITS-1:0] seen_next;
    logic                j_vld_reg;
    logic [CNT_BITS-1:0] j_seen_reg;
    logic                j_eos_reg;
    logic [LEAD:0]       j_mask;
    logic                j_tested;

    // Job tags and candidate samples travelling beside the arithmetic.
    logic                                   s1_vld_reg;
    logic                                   s2_vld_reg;
    logic                                   s3_vld_reg;
    logic [LEAD:0]                          s1_mask_reg;
    logic [LEAD:0]                          s2_mask_reg;
    logic [LEAD:0]                          s3_mask_reg;
    logic                                   s1_tested_reg;
    logic                                   s2_tested_reg;
    logic                                   s3_tested_reg;
    logic                                   s1_eos_reg;
    logic                                   s2_eos_reg;
    logic                                   s3_eos_reg;
    logic [swor_pkg::STAMP_BITS-1:0]        s1_stamp_reg [LEAD+1];
    logic [swor_pkg::STAMP_BITS-1:0]        s2_stamp_reg [LEAD+1];
    logic [swor_pkg::STAMP_BITS-1:0]        s3_stamp_reg [LEAD+1];
    logic signed [swor_pkg::VALUE_BITS-1:0] s1_value_reg [LEAD+1];
    logic signed [swor_pkg::VALUE_BITS-1:0] s2_value_reg [LEAD+1];
    logic signed [swor_pkg::VALUE_BITS-1:0] s3_value_reg [LEAD+1];
    logic [LEAD:0]                          emit_mask;

    assign sample_ready = adv;
    assign accept       = sample_valid && adv;

    // Chain of window cells.
    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        if (k == HIST)
        begin : g_head
            swor_cell u_cell (
                .clk        (clk),
                .shift      (accept),
                .en         (adv),
                .load_stamp (sample_item.stamp),
                .load_value (sample_item.sample),
                .centre     (cell_value[PRE]),
                .stamp      (cell_stamp[k]),
                .value      (cell_value[k]),
                .diff       (cell_diff[k]),
                .sq         (cell_sq[k])
            );
        end
        else
        begin : g_body
            swor_cell u_cell (
                .clk        (clk),
                .shift      (accept),
                .en         (adv),
                .load_stamp (cell_stamp[k+1]),
                .load_value (cell_value[k+1]),
                .centre     (cell_value[PRE]),
                .stamp      (cell_stamp[k]),
                .value      (cell_value[k]),
                .diff       (cell_diff[k]),
                .sq         (cell_sq[k])
            );
        end
    end

    // Window statistics and verdict for the job in the last stage.
    swor_judge #(
        .WINDOW (WINDOW)
    ) u_judge (
        .clk  (clk),
        .en   (adv),
        .diff (cell_diff),
        .sq   (cell_sq),
        .keep (keep)
    );

    // Valid history grows to HIST and restarts after the end of a stream.
    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            if (sample_item.end_of_stream)
            begin
                seen_next = '0;
            end
            else if (seen_reg != CNT_BITS'(HIST))
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    // Slots to emit: the centre always, the following slots only on end of stream,
    // and never a slot that holds no sample of this stream.
    always_comb
    begin
        for (int j = 0; j <= LEAD; j++)
        begin
            j_mask[j] = ((j == 0) || j_eos_reg) && (int'(j_seen_reg) + PRE + j >= HIST);
        end
        j_tested = (j_seen_reg == CNT_BITS'(HIST));
    end

    // A tested centre that fails is removed from the emit set.
    assign emit_mask = s3_mask_reg & ~{{LEAD{1'b0}}, s3_tested_reg && !keep};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            j_vld_reg  <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
            if (adv)
            begin
                j_vld_reg  <= accept;
                s1_vld_reg <= j_vld_reg;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            j_seen_reg <= seen_reg;
            j_eos_reg  <= sample_item.end_of_stream;
        end
        if (adv)
        begin
            s1_mask_reg   <= j_mask;
            s1_tested_reg <= j_tested;
            s1_eos_reg    <= j_eos_reg;
            s2_mask_reg   <= s1_mask_reg;
            s2_tested_reg <= s1_tested_reg;
            s2_eos_reg    <= s1_eos_reg;
            s3_mask_reg   <= s2_mask_reg;
            s3_tested_reg <= s2_tested_reg;
            s3_eos_reg    <= s2_eos_reg;
            for (int j = 0; j <= LEAD; j++)
            begin
                s1_stamp_reg[j] <= cell_stamp[PRE+j];
                s1_value_reg[j] <= cell_value[PRE+j];
                s2_stamp_reg[j] <= s1_stamp_reg[j];
                s2_value_reg[j] <= s1_value_reg[j];
                s3_stamp_reg[j] <= s2_stamp_reg[j];
                s3_value_reg[j] <= s2_value_reg[j];
            end
        end
    end

    // Result sequencer; its readiness paces the whole pipeline.
    swor_emit #(
        .WINDOW (WINDOW)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (s3_vld_reg),
        .job_ready    (adv),
        .job_mask     (emit_mask),
        .job_eos      (s3_eos_reg),
        .job_stamp    (s3_stamp_reg),
        .job_value    (s3_value_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

`ifndef SYNTHESIS
    // The history count never passes the window depth.
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CNT_BITS'(HIST))
        else $error("history count out of range");

    // A tested centre always has its slot selected before the verdict.
    a_tested_centre: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg && s3_tested_reg |-> s3_mask_reg[0])
        else $error("tested centre not selected");

    // An end-of-stream job always flushes the final sample itself.
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg && s3_eos_reg |-> s3_mask_reg[LEAD])
        else $error("end-of-stream job does not emit the final sample");

    // Every result counts at least itself.
    a_kept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_item.kept_total != '0)
        else $error("result with zero kept count");
`endif

endmodule

`default_nettype wire
